// File: rtl/core/rv64ex_pkg.sv
// rv64ex_pkg: operation codes, transaction types and helpers for the rv64i execute stage
// standalone package, used by rv64i_integer_execute
`default_nettype none

package rv64ex_pkg;

  localparam int unsigned XLEN = 64;
  localparam logic [XLEN-1:0] PC_STEP = 64'd4;
  localparam logic [XLEN-1:0] JALR_MASK = 64'hffff_ffff_ffff_fffe;

  typedef enum logic [5:0] {
    OP_ADD    = 6'd0,  OP_SUB    = 6'd1,  OP_XOR    = 6'd2,  OP_OR     = 6'd3,
    OP_AND    = 6'd4,  OP_SLL    = 6'd5,  OP_SRL    = 6'd6,  OP_SRA    = 6'd7,
    OP_SLT    = 6'd8,  OP_SLTU   = 6'd9,  OP_ADDI   = 6'd10, OP_XORI   = 6'd11,
    OP_ORI    = 6'd12, OP_ANDI   = 6'd13, OP_SLLI   = 6'd14, OP_SRLI   = 6'd15,
    OP_SRAI   = 6'd16, OP_SLTI   = 6'd17, OP_SLTIU  = 6'd18, OP_LB     = 6'd19,
    OP_LH     = 6'd20, OP_LW     = 6'd21, OP_LBU    = 6'd22, OP_LHU    = 6'd23,
    OP_SB     = 6'd24, OP_SH     = 6'd25, OP_SW     = 6'd26, OP_BEQ    = 6'd27,
    OP_BNE    = 6'd28, OP_BLT    = 6'd29, OP_BGE    = 6'd30, OP_BLTU   = 6'd31,
    OP_BGEU   = 6'd32, OP_JAL    = 6'd33, OP_JALR   = 6'd34, OP_LUI    = 6'd35,
    OP_AUIPC  = 6'd36, OP_ECALL  = 6'd37, OP_EBREAK = 6'd38, OP_URET   = 6'd39,
    OP_SRET   = 6'd40, OP_MRET   = 6'd41, OP_WFI    = 6'd42, OP_SFENCE = 6'd43,
    OP_LWU    = 6'd44, OP_LD     = 6'd45, OP_SD     = 6'd46, OP_ADDIW  = 6'd47,
    OP_SLLIW  = 6'd48, OP_SRLIW  = 6'd49, OP_SRAIW  = 6'd50, OP_ADDW   = 6'd51,
    OP_SUBW   = 6'd52, OP_SLLW   = 6'd53, OP_SRLW   = 6'd54, OP_SRAW   = 6'd55
  } op_e_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_kind_t;

  typedef enum logic [1:0] {
    SIZE_BYTE   = 2'd0,
    SIZE_HALF   = 2'd1,
    SIZE_WORD   = 2'd2,
    SIZE_DOUBLE = 2'd3
  } mem_size_t;

  typedef enum logic [2:0] {
    TRAP_NONE   = 3'd0,
    TRAP_ECALL  = 3'd1,
    TRAP_EBREAK = 3'd2,
    TRAP_URET   = 3'd3,
    TRAP_SRET   = 3'd4,
    TRAP_MRET   = 3'd5,
    TRAP_WFI    = 3'd6,
    TRAP_SFENCE = 3'd7
  } trap_kind_t;

  typedef struct packed {
    logic [5:0]        op;
    logic [XLEN-1:0]   src_a;
    logic [XLEN-1:0]   src_b;
    logic signed [31:0] immediate;
    logic [XLEN-1:0]   cur_pc;
  } in_item_t;

  typedef struct packed {
    logic [XLEN-1:0] rd_value;
    logic            rd_write;
    logic            redirect;
    logic [XLEN-1:0] next_pc;
    logic [XLEN-1:0] mem_addr;
    logic [1:0]      mem_kind;
    logic [1:0]      mem_size;
    logic            mem_signed;
    logic [XLEN-1:0] store_data;
    logic [2:0]      trap_kind;
  } out_item_t;

  // sign-extend a 32-bit word to 64 bits
  function automatic logic [XLEN-1:0] sext32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rv64i_integer_execute.sv
// rv64i_integer_execute: execute stage of an rv64i core (alu, branch, jump, memory address)
// depends on rv64ex_pkg for operation codes and transaction types
`default_nettype none

// usage
//   input channel: in_valid / in_stall / in_data carry one instruction per transaction
//   (op, src_a, src_b, immediate, cur_pc); result channel: out_valid / out_stall /
//   out_data carry exactly one result transaction per instruction, in order
//   an accepted transaction is held in the input register, then shown on out_data from
//   the result register; throughput: one transaction per cycle while out_stall is low;
//   the work sits between these registers, so the sustained rate is set by that single pass
//   stall: while out_stall holds a full result register, the input register keeps
//   its transaction and in_stall rises; an empty stage keeps accepting, so up to two
//   transactions sit in the block while the receiver stalls
//   reset: rst_n low empties both stages; no clearing pass, no configuration
//   unused op codes give all-zero fields except next_pc = cur_pc + 4
module rv64i_integer_execute (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire rv64ex_pkg::in_item_t in_data,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      rv64ex_pkg::out_item_t out_data
);

  // input register
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  rv64ex_pkg::in_item_t s1_data_r;

  // result register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  rv64ex_pkg::out_item_t out_data_r;
  rv64ex_pkg::out_item_t res_nxt;

  logic out_advance;
  logic in_take;

  // result register can load when empty or being drained this cycle
  assign out_advance = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !out_advance;
  assign in_take     = in_valid && !in_stall;

  // input register fills on a take, else holds only while its transaction cannot move on
  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_advance);
  assign out_valid_nxt = out_advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (out_advance && s1_valid_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // operands of the registered instruction
  logic [63:0] a, b, imm, pc;
  logic [63:0] sum_ab, diff_ab, sum_ai, pc_link, pc_target;
  logic [31:0] word_sum_ai, word_sum_ab, word_diff_ab;
  logic [5:0]  sh6b, sh6i;
  logic [4:0]  sh5b, sh5i;
  logic        lt_s, lt_u, lti_s, lti_u, eq_ab;
  logic        cond;
  logic        is_branch;

  assign a   = s1_data_r.src_a;
  assign b   = s1_data_r.src_b;
  assign imm = rv64ex_pkg::sext32(s1_data_r.immediate);
  assign pc  = s1_data_r.cur_pc;

  // shared adders and comparators, all working in parallel
  assign sum_ab    = a + b;
  assign diff_ab   = a - b;
  assign sum_ai    = a + imm;
  assign pc_link   = pc + rv64ex_pkg::PC_STEP;
  assign pc_target = pc + imm;

  assign word_sum_ai  = sum_ai[31:0];
  assign word_sum_ab  = sum_ab[31:0];
  assign word_diff_ab = diff_ab[31:0];

  // shift amounts: 6 bits for 64-bit shifts, 5 bits for word shifts
  assign sh6b = b[5:0];
  assign sh6i = imm[5:0];
  assign sh5b = b[4:0];
  assign sh5i = imm[4:0];

  assign lt_s  = $signed(a) < $signed(b);
  assign lt_u  = a < b;
  assign lti_s = $signed(a) < $signed(imm);
  assign lti_u = a < imm;
  assign eq_ab = a == b;

  always_comb begin
    res_nxt            = '0;
    res_nxt.next_pc    = pc_link;
    res_nxt.mem_kind   = rv64ex_pkg::MEM_NONE;
    res_nxt.mem_size   = rv64ex_pkg::SIZE_BYTE;
    res_nxt.trap_kind  = rv64ex_pkg::TRAP_NONE;
    cond               = 1'b0;
    is_branch          = 1'b0;

    case (s1_data_r.op)
      // register-register alu
      rv64ex_pkg::OP_ADD:  res_nxt.rd_value = sum_ab;
      rv64ex_pkg::OP_SUB:  res_nxt.rd_value = diff_ab;
      rv64ex_pkg::OP_XOR:  res_nxt.rd_value = a ^ b;
      rv64ex_pkg::OP_OR:   res_nxt.rd_value = a | b;
      rv64ex_pkg::OP_AND:  res_nxt.rd_value = a & b;
      rv64ex_pkg::OP_SLL:  res_nxt.rd_value = a << sh6b;
      rv64ex_pkg::OP_SRL:  res_nxt.rd_value = a >> sh6b;
      rv64ex_pkg::OP_SRA:  res_nxt.rd_value = 64'($signed(a) >>> sh6b);
      rv64ex_pkg::OP_SLT:  res_nxt.rd_value = {63'd0, lt_s};
      rv64ex_pkg::OP_SLTU: res_nxt.rd_value = {63'd0, lt_u};
      // register-immediate alu
      rv64ex_pkg::OP_ADDI:  res_nxt.rd_value = sum_ai;
      rv64ex_pkg::OP_XORI:  res_nxt.rd_value = a ^ imm;
      rv64ex_pkg::OP_ORI:   res_nxt.rd_value = a | imm;
      rv64ex_pkg::OP_ANDI:  res_nxt.rd_value = a & imm;
      rv64ex_pkg::OP_SLLI:  res_nxt.rd_value = a << sh6i;
      rv64ex_pkg::OP_SRLI:  res_nxt.rd_value = a >> sh6i;
      rv64ex_pkg::OP_SRAI:  res_nxt.rd_value = 64'($signed(a) >>> sh6i);
      rv64ex_pkg::OP_SLTI:  res_nxt.rd_value = {63'd0, lti_s};
      rv64ex_pkg::OP_SLTIU: res_nxt.rd_value = {63'd0, lti_u};
      // loads: address and access shape only
      rv64ex_pkg::OP_LB, rv64ex_pkg::OP_LH, rv64ex_pkg::OP_LW,
      rv64ex_pkg::OP_LBU, rv64ex_pkg::OP_LHU, rv64ex_pkg::OP_LWU,
      rv64ex_pkg::OP_LD: begin
        res_nxt.mem_addr = sum_ai;
        res_nxt.mem_kind = rv64ex_pkg::MEM_LOAD;
      end
      // stores
      rv64ex_pkg::OP_SB, rv64ex_pkg::OP_SH, rv64ex_pkg::OP_SW,
      rv64ex_pkg::OP_SD: begin
        res_nxt.mem_addr = sum_ai;
        res_nxt.mem_kind = rv64ex_pkg::MEM_STORE;
      end
      // branches
      rv64ex_pkg::OP_BEQ: begin
        is_branch = 1'b1;
        cond      = eq_ab;
      end
      rv64ex_pkg::OP_BNE: begin
        is_branch = 1'b1;
        cond      = !eq_ab;
      end
      rv64ex_pkg::OP_BLT: begin
        is_branch = 1'b1;
        cond      = lt_s;
      end
      rv64ex_pkg::OP_BGE: begin
        is_branch = 1'b1;
        cond      = !lt_s;
      end
      rv64ex_pkg::OP_BLTU: begin
        is_branch = 1'b1;
        cond      = lt_u;
      end
      rv64ex_pkg::OP_BGEU: begin
        is_branch = 1'b1;
        cond      = !lt_u;
      end
      // jumps write the link value and redirect
      rv64ex_pkg::OP_JAL: begin
        res_nxt.rd_value = pc_link;
        res_nxt.redirect = 1'b1;
        res_nxt.next_pc  = pc_target;
      end
      rv64ex_pkg::OP_JALR: begin
        res_nxt.rd_value = pc_link;
        res_nxt.redirect = 1'b1;
        res_nxt.next_pc  = sum_ai & rv64ex_pkg::JALR_MASK;
      end
      rv64ex_pkg::OP_LUI:   res_nxt.rd_value = imm;
      rv64ex_pkg::OP_AUIPC: res_nxt.rd_value = pc_target;
      // system ops
      rv64ex_pkg::OP_ECALL:  res_nxt.trap_kind = rv64ex_pkg::TRAP_ECALL;
      rv64ex_pkg::OP_EBREAK: res_nxt.trap_kind = rv64ex_pkg::TRAP_EBREAK;
      rv64ex_pkg::OP_URET:   res_nxt.trap_kind = rv64ex_pkg::TRAP_URET;
      rv64ex_pkg::OP_SRET:   res_nxt.trap_kind = rv64ex_pkg::TRAP_SRET;
      rv64ex_pkg::OP_MRET:   res_nxt.trap_kind = rv64ex_pkg::TRAP_MRET;
      rv64ex_pkg::OP_WFI:    res_nxt.trap_kind = rv64ex_pkg::TRAP_WFI;
      rv64ex_pkg::OP_SFENCE: res_nxt.trap_kind = rv64ex_pkg::TRAP_SFENCE;
      // word ops: low 32 bits, sign-extended
      rv64ex_pkg::OP_ADDIW: res_nxt.rd_value = rv64ex_pkg::sext32(word_sum_ai);
      rv64ex_pkg::OP_SLLIW: res_nxt.rd_value = rv64ex_pkg::sext32(a[31:0] << sh5i);
      rv64ex_pkg::OP_SRLIW: res_nxt.rd_value = rv64ex_pkg::sext32(a[31:0] >> sh5i);
      rv64ex_pkg::OP_SRAIW:
        res_nxt.rd_value = rv64ex_pkg::sext32(32'($signed(a[31:0]) >>> sh5i));
      rv64ex_pkg::OP_ADDW:  res_nxt.rd_value = rv64ex_pkg::sext32(word_sum_ab);
      rv64ex_pkg::OP_SUBW:  res_nxt.rd_value = rv64ex_pkg::sext32(word_diff_ab);
      rv64ex_pkg::OP_SLLW:  res_nxt.rd_value = rv64ex_pkg::sext32(a[31:0] << sh5b);
      rv64ex_pkg::OP_SRLW:  res_nxt.rd_value = rv64ex_pkg::sext32(a[31:0] >> sh5b);
      rv64ex_pkg::OP_SRAW:
        res_nxt.rd_value = rv64ex_pkg::sext32(32'($signed(a[31:0]) >>> sh5b));
      default: res_nxt.rd_value = '0;
    endcase

    // destination written for alu, upper-immediate, jump and word ops
    case (s1_data_r.op)
      rv64ex_pkg::OP_ADD, rv64ex_pkg::OP_SUB, rv64ex_pkg::OP_XOR, rv64ex_pkg::OP_OR,
      rv64ex_pkg::OP_AND, rv64ex_pkg::OP_SLL, rv64ex_pkg::OP_SRL, rv64ex_pkg::OP_SRA,
      rv64ex_pkg::OP_SLT, rv64ex_pkg::OP_SLTU, rv64ex_pkg::OP_ADDI, rv64ex_pkg::OP_XORI,
      rv64ex_pkg::OP_ORI, rv64ex_pkg::OP_ANDI, rv64ex_pkg::OP_SLLI, rv64ex_pkg::OP_SRLI,
      rv64ex_pkg::OP_SRAI, rv64ex_pkg::OP_SLTI, rv64ex_pkg::OP_SLTIU, rv64ex_pkg::OP_JAL,
      rv64ex_pkg::OP_JALR, rv64ex_pkg::OP_LUI, rv64ex_pkg::OP_AUIPC, rv64ex_pkg::OP_ADDIW,
      rv64ex_pkg::OP_SLLIW, rv64ex_pkg::OP_SRLIW, rv64ex_pkg::OP_SRAIW, rv64ex_pkg::OP_ADDW,
      rv64ex_pkg::OP_SUBW, rv64ex_pkg::OP_SLLW, rv64ex_pkg::OP_SRLW, rv64ex_pkg::OP_SRAW:
        res_nxt.rd_write = 1'b1;
      default: res_nxt.rd_write = 1'b0;
    endcase

    // access size, load signedness and store data
    case (s1_data_r.op)
      rv64ex_pkg::OP_LB: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_BYTE;
        res_nxt.mem_signed = 1'b1;
      end
      rv64ex_pkg::OP_LH: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_HALF;
        res_nxt.mem_signed = 1'b1;
      end
      rv64ex_pkg::OP_LW: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_WORD;
        res_nxt.mem_signed = 1'b1;
      end
      rv64ex_pkg::OP_LBU: res_nxt.mem_size = rv64ex_pkg::SIZE_BYTE;
      rv64ex_pkg::OP_LHU: res_nxt.mem_size = rv64ex_pkg::SIZE_HALF;
      rv64ex_pkg::OP_LWU: res_nxt.mem_size = rv64ex_pkg::SIZE_WORD;
      rv64ex_pkg::OP_LD:  res_nxt.mem_size = rv64ex_pkg::SIZE_DOUBLE;
      rv64ex_pkg::OP_SB: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_BYTE;
        res_nxt.store_data = {56'd0, b[7:0]};
      end
      rv64ex_pkg::OP_SH: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_HALF;
        res_nxt.store_data = {48'd0, b[15:0]};
      end
      rv64ex_pkg::OP_SW: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_WORD;
        res_nxt.store_data = {32'd0, b[31:0]};
      end
      rv64ex_pkg::OP_SD: begin
        res_nxt.mem_size   = rv64ex_pkg::SIZE_DOUBLE;
        res_nxt.store_data = b;
      end
      default: res_nxt.mem_signed = 1'b0;
    endcase

    // taken branch redirects to pc + immediate
    if (is_branch && cond) begin
      res_nxt.redirect = 1'b1;
      res_nxt.next_pc  = pc_target;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/rv64ex_exec_board_pkg.sv
// rv64ex_exec_board_pkg: result predictor and in-order checker for the rv64i execute stage
// depends on rv64ex_pkg for operation codes and transaction types
package rv64ex_exec_board_pkg;

  import rv64ex_pkg::*;

  class exec_result_board;

    out_item_t   pending_results[$];
    int unsigned mismatches;

    // low word sign-extended to full width
    function logic [XLEN-1:0] widen(logic [31:0] w);
      return {{32{w[31]}}, w};
    endfunction

    // architectural outcome of one instruction
    function out_item_t execute_instr(in_item_t t);
      out_item_t       r;
      logic [XLEN-1:0] a, b, imm, pc;
      logic [5:0]      sh_b, sh_i;
      logic [4:0]      wsh_b, wsh_i;
      logic            is_branch, take;
      r = '0;
      a = t.src_a;
      b = t.src_b;
      pc = t.cur_pc;
      imm = {{32{t.immediate[31]}}, t.immediate};
      sh_b = b[5:0];
      sh_i = imm[5:0];
      wsh_b = b[4:0];
      wsh_i = imm[4:0];
      is_branch = 1'b0;
      take = 1'b0;
      r.next_pc = pc + PC_STEP;
      case (t.op)
        OP_ADD:    r.rd_value = a + b;
        OP_SUB:    r.rd_value = a - b;
        OP_XOR:    r.rd_value = a ^ b;
        OP_OR:     r.rd_value = a | b;
        OP_AND:    r.rd_value = a & b;
        OP_SLL:    r.rd_value = a << sh_b;
        OP_SRL:    r.rd_value = a >> sh_b;
        OP_SRA:    r.rd_value = $signed(a) >>> sh_b;
        OP_SLT:    r.rd_value = {63'd0, $signed(a) < $signed(b)};
        OP_SLTU:   r.rd_value = {63'd0, a < b};
        OP_ADDI:   r.rd_value = a + imm;
        OP_XORI:   r.rd_value = a ^ imm;
        OP_ORI:    r.rd_value = a | imm;
        OP_ANDI:   r.rd_value = a & imm;
        OP_SLLI:   r.rd_value = a << sh_i;
        OP_SRLI:   r.rd_value = a >> sh_i;
        OP_SRAI:   r.rd_value = $signed(a) >>> sh_i;
        OP_SLTI:   r.rd_value = {63'd0, $signed(a) < $signed(imm)};
        OP_SLTIU:  r.rd_value = {63'd0, a < imm};
        OP_LB: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_BYTE; r.mem_signed = 1'b1;
        end
        OP_LH: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_HALF; r.mem_signed = 1'b1;
        end
        OP_LW: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_WORD; r.mem_signed = 1'b1;
        end
        OP_LBU: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_BYTE;
        end
        OP_LHU: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_HALF;
        end
        OP_LWU: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_WORD;
        end
        OP_LD: begin
          r.mem_kind = MEM_LOAD; r.mem_size = SIZE_DOUBLE;
        end
        OP_SB: begin
          r.mem_kind = MEM_STORE; r.mem_size = SIZE_BYTE;
        end
        OP_SH: begin
          r.mem_kind = MEM_STORE; r.mem_size = SIZE_HALF;
        end
        OP_SW: begin
          r.mem_kind = MEM_STORE; r.mem_size = SIZE_WORD;
        end
        OP_SD: begin
          r.mem_kind = MEM_STORE; r.mem_size = SIZE_DOUBLE;
        end
        OP_BEQ: begin
          is_branch = 1'b1; take = (a == b);
        end
        OP_BNE: begin
          is_branch = 1'b1; take = (a != b);
        end
        OP_BLT: begin
          is_branch = 1'b1; take = $signed(a) < $signed(b);
        end
        OP_BGE: begin
          is_branch = 1'b1; take = !($signed(a) < $signed(b));
        end
        OP_BLTU: begin
          is_branch = 1'b1; take = (a < b);
        end
        OP_BGEU: begin
          is_branch = 1'b1; take = (a >= b);
        end
        OP_JAL: begin
          r.rd_value = pc + PC_STEP; r.redirect = 1'b1; r.next_pc = pc + imm;
        end
        OP_JALR: begin
          r.rd_value = pc + PC_STEP; r.redirect = 1'b1; r.next_pc = (a + imm) & JALR_MASK;
        end
        OP_LUI:    r.rd_value = imm;
        OP_AUIPC:  r.rd_value = pc + imm;
        OP_ECALL:  r.trap_kind = TRAP_ECALL;
        OP_EBREAK: r.trap_kind = TRAP_EBREAK;
        OP_URET:   r.trap_kind = TRAP_URET;
        OP_SRET:   r.trap_kind = TRAP_SRET;
        OP_MRET:   r.trap_kind = TRAP_MRET;
        OP_WFI:    r.trap_kind = TRAP_WFI;
        OP_SFENCE: r.trap_kind = TRAP_SFENCE;
        OP_ADDIW:  r.rd_value = widen(a[31:0] + imm[31:0]);
        OP_SLLIW:  r.rd_value = widen(a[31:0] << wsh_i);
        OP_SRLIW:  r.rd_value = widen(a[31:0] >> wsh_i);
        OP_SRAIW:  r.rd_value = widen($signed(a[31:0]) >>> wsh_i);
        OP_ADDW:   r.rd_value = widen(a[31:0] + b[31:0]);
        OP_SUBW:   r.rd_value = widen(a[31:0] - b[31:0]);
        OP_SLLW:   r.rd_value = widen(a[31:0] << wsh_b);
        OP_SRLW:   r.rd_value = widen(a[31:0] >> wsh_b);
        OP_SRAW:   r.rd_value = widen($signed(a[31:0]) >>> wsh_b);
        default:   ;
      endcase
      // everything except memory, branch, system and unused codes writes rd
      r.rd_write = (t.op <= OP_SRAW) && !is_branch && (r.mem_kind == MEM_NONE)
                   && (r.trap_kind == TRAP_NONE);
      if (take) begin
        r.redirect = 1'b1;
        r.next_pc = pc + imm;
      end
      if (r.mem_kind != MEM_NONE) r.mem_addr = a + imm;
      if (r.mem_kind == MEM_STORE) begin
        case (r.mem_size)
          SIZE_BYTE: r.store_data = {56'd0, b[7:0]};
          SIZE_HALF: r.store_data = {48'd0, b[15:0]};
          SIZE_WORD: r.store_data = {32'd0, b[31:0]};
          default:   r.store_data = b;
        endcase
      end
      return r;
    endfunction

    function void note_instr(in_item_t t);
      pending_results.push_back(execute_instr(t));
    endfunction

    function void show_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
      if (want !== got) $display("  %s: expected %h, got %h", name, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transaction with none pending: %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $time);
          show_field("rd_value", want.rd_value, got.rd_value);
          show_field("rd_write", want.rd_write, got.rd_write);
          show_field("redirect", want.redirect, got.redirect);
          show_field("next_pc", want.next_pc, got.next_pc);
          show_field("mem_addr", want.mem_addr, got.mem_addr);
          show_field("mem_kind", want.mem_kind, got.mem_kind);
          show_field("mem_size", want.mem_size, got.mem_size);
          show_field("mem_signed", want.mem_signed, got.mem_signed);
          show_field("store_data", want.store_data, got.store_data);
          show_field("trap_kind", want.trap_kind, got.trap_kind);
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

  endclass

endpackage

// File: tb/sv/tb_rv64i_integer_execute.sv
// tb_rv64i_integer_execute: directed and random instruction stream through the execute stage,
// with random idling on both channels; depends on rv64ex_pkg and rv64ex_exec_board_pkg
module tb_rv64i_integer_execute;
  timeunit 1ns;
  timeprecision 1ps;

  import rv64ex_pkg::*;
  import rv64ex_exec_board_pkg::*;

  // op codes past the last defined one
  localparam logic [5:0] OP_UNUSED_FIRST = 6'd56;
  localparam logic [5:0] OP_UNUSED_LAST  = 6'd63;
  localparam logic [XLEN-1:0] SIGN_BIT   = {1'b1, 63'd0};
  localparam logic [XLEN-1:0] MAX_POS    = {1'b0, {63{1'b1}}};
  localparam int unsigned RANDOM_PER_PHASE = 250;
  // two-stage pipe, so a handful of cycles covers any straggler
  localparam int unsigned SETTLE_CYCLES = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // idle percentages for the current phase
  int unsigned gap_pct;
  int unsigned stall_pct;

  exec_result_board board = new();

  rv64i_integer_execute DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both monitors see pre-edge values, so acceptance is exactly valid and not stall
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_instr(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // result-side backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // present one instruction and hold it until the block takes it
  // entered and left just after a falling edge
  task automatic drive_instr(input in_item_t item);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sender goes quiet until every predicted result has come back
  task automatic pause_until_drained(input int unsigned next_gap, input int unsigned next_stall);
    in_valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
    gap_pct = next_gap;
    stall_pct = next_stall;
    @(negedge clk);
  endtask

  function automatic in_item_t instr(input logic [5:0] op, input logic [XLEN-1:0] a,
                                     input logic [XLEN-1:0] b, input logic [31:0] imm,
                                     input logic [XLEN-1:0] pc);
    in_item_t t;
    t.op = op;
    t.src_a = a;
    t.src_b = b;
    t.immediate = imm;
    t.cur_pc = pc;
    return t;
  endfunction

  // register values biased toward the corners of signed and unsigned compares
  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return SIGN_BIT;
      3: return MAX_POS;
      4: return {32'd0, $urandom()};
      5: return 64'($urandom_range(63));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] pick_immediate();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(127)) - 32'd64;
      3: return 32'($urandom_range(63));  // shift amounts
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_instr();
    in_item_t t;
    // mostly real ops, a few unused codes
    if ($urandom_range(99) < 6) t.op = 6'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    else t.op = 6'($urandom_range(OP_SRAW));
    t.src_a = pick_operand();
    t.src_b = pick_operand();
    // equal operands often enough for beq/bge/bgeu to take
    if (t.op >= OP_BEQ && t.op <= OP_BGEU && $urandom_range(2) == 0) t.src_b = t.src_a;
    t.immediate = pick_immediate();
    if ($urandom_range(1)) t.cur_pc = {$urandom(), $urandom()};
    else t.cur_pc = {32'd0, $urandom() & 32'hffff_fffc};
    return t;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) drive_instr(random_instr());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    drive_instr(instr(OP_ADD, '1, 64'd1, 32'd0, 64'h0));                  // add wraps
    drive_instr(instr(OP_SUB, '0, 64'd1, 32'd0, 64'h1000));
    drive_instr(instr(OP_SLL, 64'd1, '1, 32'd0, 64'h1004));               // amount masked to 63
    drive_instr(instr(OP_SRL, '1, 64'h40, 32'd0, 64'h1008));              // 64 masks to zero
    drive_instr(instr(OP_SRA, SIGN_BIT, 64'h7f, 32'd0, 64'h100c));
    drive_instr(instr(OP_SRAI, SIGN_BIT, '0, 32'hffff_ffff, 64'h1010));
    drive_instr(instr(OP_SLT, SIGN_BIT, '0, 32'd0, 64'h1014));            // negative < zero
    drive_instr(instr(OP_SLTU, SIGN_BIT, '0, 32'd0, 64'h1018));
    drive_instr(instr(OP_SLTIU, 64'd5, '0, 32'hffff_ffff, 64'h101c));     // imm widens to all ones
    drive_instr(instr(OP_XORI, MAX_POS, '0, 32'h8000_0000, 64'h1020));
    drive_instr(instr(OP_ADDW, 64'h7fff_ffff, 64'd1, 32'd0, 64'h1024));   // word overflow
    drive_instr(instr(OP_SLLIW, 64'hffff_ffff_8000_0001, '0, 32'h3f, 64'h1028));
    drive_instr(instr(OP_SRAIW, 64'h8000_0000, '0, 32'd31, 64'h102c));
    drive_instr(instr(OP_SRLW, '1, 64'h20, 32'd0, 64'h1030));             // word amount masked
    drive_instr(instr(OP_JAL, '0, '0, 32'd8, 64'hffff_ffff_ffff_fffc));   // target wraps
    drive_instr(instr(OP_JALR, 64'h1001, '0, 32'd0, 64'h1034));           // bit 0 cleared
    drive_instr(instr(OP_BEQ, 64'h55, 64'h55, 32'hffff_fff0, 64'h1038));  // taken backward
    drive_instr(instr(OP_BLT, 64'd1, SIGN_BIT, 32'd16, 64'h103c));        // not taken
    drive_instr(instr(OP_BGEU, '1, '1, 32'd12, 64'h1040));
    drive_instr(instr(OP_LB, '1, '0, 32'd1, 64'h1044));                   // address wraps
    drive_instr(instr(OP_LD, 64'h2000, '0, 32'hffff_fff8, 64'h1048));
    drive_instr(instr(OP_SB, 64'h3000, '1, 32'd3, 64'h104c));
    drive_instr(instr(OP_SW, 64'h3000, '1, 32'd4, 64'h1050));
    drive_instr(instr(OP_SD, 64'h3000, '1, 32'd8, 64'h1054));
    drive_instr(instr(OP_LUI, '0, '0, 32'h8000_0000, 64'h1058));
    drive_instr(instr(OP_ECALL, '1, '1, 32'hffff_ffff, 64'h105c));
    drive_instr(instr(OP_SFENCE, '1, '1, 32'hffff_ffff, 64'h1060));
    drive_instr(instr(OP_UNUSED_LAST, '1, '1, 32'hffff_ffff, '1));        // unused code

    // sender light, receiver heavy
    pause_until_drained(20, 79);
    run_random(RANDOM_PER_PHASE);
    // sender heavy, receiver light
    pause_until_drained(79, 20);
    run_random(RANDOM_PER_PHASE);
    // back to back
    pause_until_drained(0, 0);
    run_random(RANDOM_PER_PHASE);

    pause_until_drained(0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
